// File: rtl/timeout_priority_queue_assert.svh
// Assertion macros for the timeout priority queue.
// Included by the top level; needs nothing else.
`ifndef TIMEOUT_PRIORITY_QUEUE_ASSERT_SVH
`define TIMEOUT_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define TPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define TPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tpq_pkg.sv
// Shared types, constants and helpers of the timeout priority queue.
// Used by tpq_cell and timeout_priority_queue; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tpq_pkg;

    localparam int SLOTS    = 16;
    localparam int SLOT_IDS = 16;
    localparam int SLOT_W   = 4;
    localparam int DL_W     = 32;
    localparam int TO_W     = 16;
    localparam int POS_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);

    localparam logic [CNT_W-1:0] COUNT_FULL      = CNT_W'(SLOTS);
    localparam logic [POS_W-1:0] POS_LAST        = POS_W'(SLOTS - 1);
    localparam logic [TO_W-1:0]  DEFAULT_TIMEOUT = 16'd500;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_REARM  = 3'd3,
        CMD_QUERY  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_EXPIRED = 2'd0,
        KIND_WAIT    = 2'd1,
        KIND_EMPTY   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EXPIRE
    } t_state;

    // Walk phases of the update word traveling down the chain.
    typedef enum logic [1:0] {
        PH_SCAN,
        PH_PUSH,
        PH_PULL
    } t_phase;

    typedef struct packed {
        logic              valid;
        logic [DL_W-1:0]   dl;
        logic [SLOT_W-1:0] owner;
    } t_entry;

    typedef struct packed {
        logic              active;
        t_phase            phase;
        logic              ins;
        logic [DL_W-1:0]   nd;
        logic [SLOT_W-1:0] nown;
        t_entry            carry;
    } t_token;

    // True when deadline a is not after deadline b in wrapping order.
    function automatic logic not_after(input logic [DL_W-1:0] a, input logic [DL_W-1:0] b);
        logic [DL_W-1:0] d;
        d = b - a;
        return ~d[DL_W-1];
    endfunction

endpackage

`default_nettype wire

// File: rtl/tpq_cell.sv
// One position of the sorted timeout chain: holds an entry and passes
// the update word one cell down per cycle. Depends on tpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpq_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire tpq_pkg::t_token i_tok,
    input  wire tpq_pkg::t_entry i_nbr,
    output tpq_pkg::t_entry      o_ent,
    output tpq_pkg::t_token      o_tok
);

    tpq_pkg::t_entry r_ent, n_ent;
    tpq_pkg::t_token r_tok, n_tok;
    tpq_pkg::t_entry new_ent;
    logic            own_hit;
    logic            fits_before_nbr;

    assign new_ent         = '{valid: 1'b1, dl: i_tok.nd, owner: i_tok.nown};
    assign own_hit         = r_ent.valid && (r_ent.owner == i_tok.nown);
    assign fits_before_nbr = i_tok.ins &&
                             (!i_nbr.valid || tpq_pkg::not_after(i_tok.nd, i_nbr.dl));

    always_comb begin
        n_ent = r_ent;
        n_tok = '0;
        if (i_shift) begin
            n_ent = i_nbr;
        end else if (i_tok.active) begin
            n_tok = i_tok;
            unique case (i_tok.phase)
                tpq_pkg::PH_SCAN: begin
                    if (own_hit) begin
                        // old entry leaves: place here or close the gap
                        if (fits_before_nbr) begin
                            n_ent        = new_ent;
                            n_tok.active = 1'b0;
                        end else begin
                            n_ent        = i_nbr;
                            n_tok.phase  = tpq_pkg::PH_PULL;
                            n_tok.active = i_nbr.valid;
                        end
                    end else if (!r_ent.valid) begin
                        if (i_tok.ins) begin
                            n_ent = new_ent;
                        end
                        n_tok.active = 1'b0;
                    end else if (i_tok.ins && tpq_pkg::not_after(i_tok.nd, r_ent.dl)) begin
                        n_ent       = new_ent;
                        n_tok.carry = r_ent;
                        n_tok.phase = tpq_pkg::PH_PUSH;
                    end
                end
                tpq_pkg::PH_PUSH: begin
                    n_ent = i_tok.carry;
                    if (!r_ent.valid || own_hit) begin
                        n_tok.active = 1'b0;
                    end else begin
                        n_tok.carry = r_ent;
                    end
                end
                tpq_pkg::PH_PULL: begin
                    if (fits_before_nbr) begin
                        n_ent        = new_ent;
                        n_tok.active = 1'b0;
                    end else begin
                        n_ent        = i_nbr;
                        n_tok.active = i_nbr.valid;
                    end
                end
                default: begin
                    n_tok.active = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= '0;
            r_tok <= '0;
        end else begin
            r_ent <= n_ent;
            r_tok <= n_tok;
        end
    end

    assign o_ent = r_ent;
    assign o_tok = r_tok;

endmodule

`default_nettype wire

// File: rtl/timeout_priority_queue.sv
// Top level of the timeout priority queue: command control, time counter
// and a chain of tpq_cell. Depends on tpq_pkg and the assertion header.
//
//  channel   ports                                         handshake
//  command   i_cmd, i_request_slot, i_timeout_ms           start & !busy
//  result    o_kind, o_expired_slot, o_wait_ms, o_last      o_strobe, one cycle
//  config    i_cfg_wdata                                    i_cfg_we
//
// Add, rearm and delete hold busy while the update word walks the chain; a
// rejected add or rearm, or an idle-slot delete, leaves busy low. Tick holds busy
// while due entries leave the head one by one, even if none is due; each expiry
// word appears the cycle after its expire cycle. Query answers the cycle after
// acceptance. Synchronous active-low reset empties the queue, zeroes time, sets
// the default timeout to 500. Results cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none
`include "timeout_priority_queue_assert.svh"

module timeout_priority_queue (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [2:0]                   i_cmd,
    input  wire logic [tpq_pkg::SLOT_W-1:0]   i_request_slot,
    input  wire logic [tpq_pkg::TO_W-1:0]     i_timeout_ms,
    output logic                              o_strobe,
    output logic [1:0]                        o_kind,
    output logic [tpq_pkg::SLOT_W-1:0]        o_expired_slot,
    output logic [tpq_pkg::TO_W-1:0]          o_wait_ms,
    output logic                              o_last,
    input  wire logic                         i_cfg_we,
    input  wire logic [tpq_pkg::TO_W-1:0]     i_cfg_wdata
);

    tpq_pkg::t_state                  r_state, n_state;
    logic [tpq_pkg::POS_W-1:0]        r_cnt, n_cnt;
    logic [tpq_pkg::DL_W-1:0]         r_now, n_now;
    logic [tpq_pkg::TO_W-1:0]         r_default;
    logic [tpq_pkg::SLOT_IDS-1:0]     r_pending, n_pending;
    logic [tpq_pkg::CNT_W-1:0]        r_count, n_count;
    tpq_pkg::t_token                  r_inject, n_inject;
    logic                             r_strobe, n_strobe;
    tpq_pkg::t_kind                   r_kind, n_kind;
    logic [tpq_pkg::SLOT_W-1:0]       r_slot, n_slot;
    logic [tpq_pkg::TO_W-1:0]         r_wait, n_wait;
    logic                             r_last, n_last;

    tpq_pkg::t_entry                  w_ent [tpq_pkg::SLOTS+1];
    tpq_pkg::t_token                  w_tok [tpq_pkg::SLOTS+1];

    tpq_pkg::t_cmd                    cmd;
    logic                             accept;
    logic                             slot_ok;
    logic                             arm_ok;
    logic                             del_ok;
    logic                             head_due;
    logic                             next_due;
    logic                             shift;
    logic [tpq_pkg::DL_W-1:0]         deadline_new;
    logic [tpq_pkg::DL_W-1:0]         qdiff;
    logic [tpq_pkg::TO_W-1:0]         qwait;

    // ---- cell chain ----
    assign w_tok[0]              = r_inject;
    assign w_ent[tpq_pkg::SLOTS] = '0;

    for (genvar gi = 0; gi < tpq_pkg::SLOTS; gi++) begin : g_cell
        tpq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_tok   (w_tok[gi]),
            .i_nbr   (w_ent[gi+1]),
            .o_ent   (w_ent[gi]),
            .o_tok   (w_tok[gi+1])
        );
    end

    // ---- decode ----
    assign cmd     = tpq_pkg::t_cmd'(i_cmd);
    assign accept  = start && !busy;
    assign slot_ok = (32'(i_request_slot) < tpq_pkg::SLOTS);
    assign arm_ok  = slot_ok &&
                     !((r_count == tpq_pkg::COUNT_FULL) && !r_pending[i_request_slot]);
    assign del_ok  = slot_ok && r_pending[i_request_slot];

    assign deadline_new = r_now + tpq_pkg::DL_W'((cmd == tpq_pkg::CMD_REARM) ?
                                                 r_default : i_timeout_ms);

    assign head_due = w_ent[0].valid && tpq_pkg::not_after(w_ent[0].dl, r_now);
    assign next_due = w_ent[1].valid && tpq_pkg::not_after(w_ent[1].dl, r_now);

    // clamp the remaining wait to 0..65535
    assign qdiff = w_ent[0].dl - r_now;
    always_comb begin
        priority if (qdiff[tpq_pkg::DL_W-1]) begin
            qwait = '0;
        end else if (|qdiff[tpq_pkg::DL_W-2:tpq_pkg::TO_W]) begin
            qwait = '1;
        end else begin
            qwait = qdiff[tpq_pkg::TO_W-1:0];
        end
    end

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tpq_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        tpq_pkg::CMD_TICK:   n_state = tpq_pkg::ST_EXPIRE;
                        tpq_pkg::CMD_ADD,
                        tpq_pkg::CMD_REARM:  n_state = arm_ok ? tpq_pkg::ST_WALK :
                                                                tpq_pkg::ST_IDLE;
                        tpq_pkg::CMD_DELETE: n_state = del_ok ? tpq_pkg::ST_WALK :
                                                                tpq_pkg::ST_IDLE;
                        default:             n_state = tpq_pkg::ST_IDLE;
                    endcase
                end
            end
            tpq_pkg::ST_WALK: begin
                if (r_cnt == tpq_pkg::POS_LAST) begin
                    n_state = tpq_pkg::ST_IDLE;
                end
            end
            tpq_pkg::ST_EXPIRE: begin
                if (!head_due || !next_due) begin
                    n_state = tpq_pkg::ST_IDLE;
                end
            end
            default: n_state = tpq_pkg::ST_IDLE;
        endcase
    end

    // ---- state outputs ----
    always_comb begin
        busy  = (r_state != tpq_pkg::ST_IDLE);
        shift = (r_state == tpq_pkg::ST_EXPIRE) && head_due;
    end

    // ---- datapath next values ----
    always_comb begin
        n_cnt     = (r_state == tpq_pkg::ST_WALK) ? tpq_pkg::POS_W'(r_cnt + 1'b1) : '0;
        n_now     = r_now;
        n_pending = r_pending;
        n_count   = r_count;
        n_inject  = '0;
        n_strobe  = 1'b0;
        n_kind    = tpq_pkg::KIND_EXPIRED;
        n_slot    = '0;
        n_wait    = '0;
        n_last    = 1'b0;
        if (accept) begin
            unique case (cmd)
                tpq_pkg::CMD_TICK: begin
                    n_now = r_now + 1'b1;
                end
                tpq_pkg::CMD_ADD,
                tpq_pkg::CMD_REARM: begin
                    if (arm_ok) begin
                        n_inject = '{active: 1'b1, phase: tpq_pkg::PH_SCAN, ins: 1'b1,
                                     nd: deadline_new, nown: i_request_slot, carry: '0};
                        n_pending[i_request_slot] = 1'b1;
                        if (!r_pending[i_request_slot]) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                end
                tpq_pkg::CMD_DELETE: begin
                    if (del_ok) begin
                        n_inject = '{active: 1'b1, phase: tpq_pkg::PH_SCAN, ins: 1'b0,
                                     nd: '0, nown: i_request_slot, carry: '0};
                        n_pending[i_request_slot] = 1'b0;
                        n_count = r_count - 1'b1;
                    end
                end
                tpq_pkg::CMD_QUERY: begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    if (w_ent[0].valid) begin
                        n_kind = tpq_pkg::KIND_WAIT;
                        n_wait = qwait;
                    end else begin
                        n_kind = tpq_pkg::KIND_EMPTY;
                    end
                end
                default: begin
                    n_strobe = 1'b0;
                end
            endcase
        end
        if (shift) begin
            // emit the head and drop it from the chain
            n_strobe                   = 1'b1;
            n_kind                     = tpq_pkg::KIND_EXPIRED;
            n_slot                     = w_ent[0].owner;
            n_last                     = !next_due;
            n_pending[w_ent[0].owner]  = 1'b0;
            n_count                    = r_count - 1'b1;
        end
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tpq_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_now     <= '0;
            r_pending <= '0;
            r_count   <= '0;
            r_inject  <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_now     <= n_now;
            r_pending <= n_pending;
            r_count   <= n_count;
            r_inject  <= n_inject;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_slot <= n_slot;
        r_wait <= n_wait;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default <= tpq_pkg::DEFAULT_TIMEOUT;
        end else if (i_cfg_we) begin
            r_default <= i_cfg_wdata;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_kind         = r_kind;
    assign o_expired_slot = r_slot;
    assign o_wait_ms      = r_wait;
    assign o_last         = r_last;

    // ---- assertions ----
    `TPQ_ASSERT_NOW(a_count_matches_pending, i_clk, i_rst_n, 1'b1, r_count == $countones(r_pending), "entry count disagrees with pending slots")
    `TPQ_ASSERT_NOW(a_idle_empty_head, i_clk, i_rst_n, (r_state == tpq_pkg::ST_IDLE) && (r_count == '0), !w_ent[0].valid, "empty queue holds a head entry")
    `TPQ_ASSERT_NEXT(a_burst_continues, i_clk, i_rst_n, r_strobe && !r_last, r_strobe && (r_kind == tpq_pkg::KIND_EXPIRED), "expiry burst broke off before last word")
    `TPQ_ASSERT_NOW(a_expiry_source, i_clk, i_rst_n, r_strobe && (r_kind == tpq_pkg::KIND_EXPIRED), $past(r_state == tpq_pkg::ST_EXPIRE), "expiry word outside expire state")

endmodule

`default_nettype wire
